// ----- rtl/core/spatial_cell_hash_table_top_macros.svh -----
// Assertion macros shared by the checker of the spatial cell hash table.
`ifndef SPATIAL_CELL_HASH_TABLE_TOP_MACROS_SVH
`define SPATIAL_CELL_HASH_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCHT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spatial cell hash table check failed");

// Next-cycle implication, disabled while reset is high.
`define SCHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spatial cell hash table check failed");

`endif

// ----- rtl/core/scht_pkg.sv -----
// Types, constants and hash functions of the spatial cell hash table.
package scht_pkg;

  localparam int BUCKETS    = 256;
  localparam int POOL_NODES = 1024;
  localparam int COORD_BITS = 16;

  localparam int BUCKET_W  = $clog2(BUCKETS);
  localparam int NODE_W    = $clog2(POOL_NODES);
  localparam int LINK_W    = NODE_W + 1;
  localparam int KEY_W     = 3 * COORD_BITS;
  localparam int HANDLE_W  = 10;
  localparam int COUNT_W   = 11;
  localparam int CLEAR_LEN = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
  localparam int CLEAR_W   = $clog2(CLEAR_LEN);

  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_GIVE   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [15:0]  pos_x;
    logic signed [15:0]  pos_y;
    logic signed [15:0]  pos_z;
    logic [HANDLE_W-1:0] handle_in;
  } item_t;

  typedef struct packed {
    logic                hit;
    logic                created;
    logic [HANDLE_W-1:0] handle_out;
    logic                pool_full;
    logic [COUNT_W-1:0]  live_count;
  } result_t;

  // Classified request passed from the front part to the back part.
  typedef struct packed {
    logic [1:0]          op;
    logic [KEY_W-1:0]    key;
    logic [BUCKET_W-1:0] bucket;
    logic [HANDLE_W-1:0] handle;
  } front_req_t;

  // Keeps the low COORD_BITS bits of an input coordinate, sign extended.
  function automatic logic signed [COORD_BITS-1:0] coord_of(logic signed [15:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    return w[COORD_BITS-1:0];
  endfunction

  // Bucket of a position: x + 8y + 64z in two's complement, masked.
  function automatic logic [BUCKET_W-1:0] hash_of(logic signed [COORD_BITS-1:0] x,
                                                  logic signed [COORD_BITS-1:0] y,
                                                  logic signed [COORD_BITS-1:0] z);
    logic [31:0] xs;
    logic [31:0] ys;
    logic [31:0] zs;
    logic [31:0] sum;
    xs = 32'(x);
    ys = 32'(y);
    zs = 32'(z);
    sum = xs + (ys << 3) + (zs << 6);
    return sum[BUCKET_W-1:0];
  endfunction

  // Bucket of a packed key.
  function automatic logic [BUCKET_W-1:0] hash_key(logic [KEY_W-1:0] k);
    return hash_of(k[COORD_BITS-1:0], k[2*COORD_BITS-1:COORD_BITS],
                   k[3*COORD_BITS-1:2*COORD_BITS]);
  endfunction

endpackage

// ----- rtl/core/scht_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module scht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/scht_front.sv -----
// Front part: accepts requests, computes key and bucket, queues them.
module scht_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  scht_pkg::item_t        item,
  output logic                   q_valid,
  output scht_pkg::front_req_t   q_req,
  input  logic                   q_pop
);

  scht_pkg::front_req_t entry [2];
  scht_pkg::front_req_t new_req;
  logic                 wptr;
  logic                 rptr;
  logic [1:0]           count;
  logic                 do_push;
  logic                 do_pop;
  logic signed [scht_pkg::COORD_BITS-1:0] cx;
  logic signed [scht_pkg::COORD_BITS-1:0] cy;
  logic signed [scht_pkg::COORD_BITS-1:0] cz;

  // Classify the incoming request: packed key and bucket.
  always_comb begin
    cx = scht_pkg::coord_of(item.pos_x);
    cy = scht_pkg::coord_of(item.pos_y);
    cz = scht_pkg::coord_of(item.pos_z);
    new_req.op     = item.op;
    new_req.key    = {cz, cy, cx};
    new_req.bucket = scht_pkg::hash_of(cx, cy, cz);
    new_req.handle = item.handle_in;
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_req   = entry[rptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // Two-entry request queue.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= new_req;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop) rptr <= !rptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- rtl/core/scht_back.sv -----
// Back part: walks bucket chains, allocates and frees nodes, holds the result.
module scht_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  scht_pkg::front_req_t q_req,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output scht_pkg::result_t    result
);

  localparam int NW = scht_pkg::NODE_W;
  localparam int LW = scht_pkg::LINK_W;
  localparam int BW = scht_pkg::BUCKET_W;
  localparam int KW = scht_pkg::KEY_W;

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_HEAD      = 4'd2;
  localparam logic [3:0] S_WALK      = 4'd3;
  localparam logic [3:0] S_CMP       = 4'd4;
  localparam logic [3:0] S_ALLOC_RD  = 4'd5;
  localparam logic [3:0] S_ALLOC_WR  = 4'd6;
  localparam logic [3:0] S_RM_LIVE   = 4'd7;
  localparam logic [3:0] S_RM_HEAD   = 4'd8;
  localparam logic [3:0] S_RM_WALK   = 4'd9;
  localparam logic [3:0] S_RM_STEP   = 4'd10;
  localparam logic [3:0] S_RM_UNLINK = 4'd11;
  localparam logic [3:0] S_RM_FIN    = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  localparam logic [LW-1:0] POOL_LINK = LW'(scht_pkg::POOL_NODES);

  logic [3:0]                     state;
  logic [scht_pkg::CLEAR_W-1:0]   clr_cnt;
  logic [1:0]                     op;
  logic [KW-1:0]                  key;
  logic [BW-1:0]                  bucket;
  logic [scht_pkg::HANDLE_W-1:0]  handle;
  logic [LW-1:0]                  cur;
  logic [LW-1:0]                  prev;
  logic [LW-1:0]                  head;
  logic [LW-1:0]                  steps;
  logic [NW-1:0]                  alloc_node;
  logic [LW-1:0]                  free_head;
  logic [LW-1:0]                  fresh;
  logic [LW-1:0]                  count;
  scht_pkg::result_t              res;
  logic                           out_valid;
  scht_pkg::result_t              out_data;

  // Memory ports.
  logic          bh_we, nx_we, ps_we, lv_we;
  logic [BW-1:0] bh_waddr, bh_raddr;
  logic [LW-1:0] bh_wdata, bh_rdata;
  logic [NW-1:0] nx_waddr, nx_raddr;
  logic [LW-1:0] nx_wdata, nx_rdata;
  logic [NW-1:0] ps_waddr, ps_raddr;
  logic [KW-1:0] ps_rdata;
  logic [NW-1:0] lv_waddr, lv_raddr;
  logic          lv_wdata, lv_rdata;

  logic          walk_end;
  logic          free_ok;
  logic [LW-1:0] target;
  logic [LW-1:0] handle_ext;
  logic [NW-1:0] cur_node;
  logic [NW-1:0] handle_node;
  logic          out_free;

  scht_ram #(.WIDTH(LW), .DEPTH(scht_pkg::BUCKETS)) u_bucket_head (
    .clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
    .raddr(bh_raddr), .rdata(bh_rdata)
  );
  scht_ram #(.WIDTH(LW), .DEPTH(scht_pkg::POOL_NODES)) u_node_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );
  scht_ram #(.WIDTH(KW), .DEPTH(scht_pkg::POOL_NODES)) u_node_pos (
    .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(key),
    .raddr(ps_raddr), .rdata(ps_rdata)
  );
  scht_ram #(.WIDTH(1), .DEPTH(scht_pkg::POOL_NODES)) u_node_live (
    .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
    .raddr(lv_raddr), .rdata(lv_rdata)
  );

  // Chain walk helpers.
  always_comb begin
    walk_end    = (cur == '0) || (cur > POOL_LINK) || (steps >= POOL_LINK);
    free_ok     = (free_head != '0) && (free_head <= POOL_LINK);
    handle_ext  = LW'(handle);
    target      = handle_ext + LW'(1);
    cur_node    = NW'(cur - LW'(1));
    handle_node = NW'(handle);
    out_free    = !out_valid || pop;
  end

  // Memory address and write control.
  always_comb begin
    bh_we    = 1'b0;
    bh_waddr = bucket;
    bh_wdata = nx_rdata;
    nx_we    = 1'b0;
    nx_waddr = handle_node;
    nx_wdata = free_head;
    ps_we    = 1'b0;
    ps_waddr = alloc_node;
    lv_we    = 1'b0;
    lv_waddr = handle_node;
    lv_wdata = 1'b0;
    bh_raddr = q_req.bucket;
    lv_raddr = NW'(q_req.handle);
    ps_raddr = (state == S_IDLE) ? NW'(q_req.handle) : cur_node;
    nx_raddr = (state == S_WALK && walk_end) ? NW'(free_head - LW'(1)) : cur_node;
    q_pop    = (state == S_IDLE) && q_valid;
    if (state == S_RM_LIVE) begin
      bh_raddr = scht_pkg::hash_key(ps_rdata);
    end
    case (state)
      S_CLEAR: begin
        bh_we    = 1'b1;
        bh_waddr = clr_cnt[BW-1:0];
        bh_wdata = '0;
        lv_we    = 1'b1;
        lv_waddr = clr_cnt[NW-1:0];
      end
      S_ALLOC_WR: begin
        bh_we    = 1'b1;
        bh_wdata = LW'(alloc_node) + LW'(1);
        nx_we    = 1'b1;
        nx_waddr = alloc_node;
        nx_wdata = head;
        ps_we    = 1'b1;
        lv_we    = 1'b1;
        lv_waddr = alloc_node;
        lv_wdata = 1'b1;
      end
      S_RM_UNLINK: begin
        if (prev == '0) begin
          bh_we = 1'b1;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = NW'(prev - LW'(1));
          nx_wdata = nx_rdata;
        end
      end
      S_RM_FIN: begin
        nx_we = 1'b1;
        lv_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      free_head <= '0;
      fresh     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Result register: load a finished result, or clear it once taken.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + scht_pkg::CLEAR_W'(1);
          if (clr_cnt == scht_pkg::CLEAR_W'(scht_pkg::CLEAR_LEN - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            op     <= q_req.op;
            key    <= q_req.key;
            bucket <= q_req.bucket;
            handle <= q_req.handle;
            res    <= '0;
            if (q_req.op == scht_pkg::OP_FIND || q_req.op == scht_pkg::OP_GIVE) begin
              state <= S_HEAD;
            end else if (q_req.op == scht_pkg::OP_REMOVE &&
                         LW'(q_req.handle) < POOL_LINK) begin
              state <= S_RM_LIVE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_HEAD: begin
          cur   <= bh_rdata;
          head  <= bh_rdata;
          steps <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          if (!walk_end) begin
            state <= S_CMP;
          end else if (op != scht_pkg::OP_GIVE) begin
            state <= S_DONE;
          end else if (free_ok) begin
            alloc_node <= NW'(free_head - LW'(1));
            state      <= S_ALLOC_RD;
          end else if (fresh < POOL_LINK) begin
            alloc_node <= NW'(fresh);
            fresh      <= fresh + LW'(1);
            state      <= S_ALLOC_WR;
          end else begin
            res.pool_full <= 1'b1;
            state         <= S_DONE;
          end
        end
        S_CMP: begin
          if (ps_rdata == key) begin
            res.hit        <= 1'b1;
            res.handle_out <= scht_pkg::HANDLE_W'(cur_node);
            state          <= S_DONE;
          end else begin
            cur   <= nx_rdata;
            steps <= steps + LW'(1);
            state <= S_WALK;
          end
        end
        S_ALLOC_RD: begin
          free_head <= nx_rdata;
          state     <= S_ALLOC_WR;
        end
        S_ALLOC_WR: begin
          count          <= count + LW'(1);
          res.created    <= 1'b1;
          res.handle_out <= scht_pkg::HANDLE_W'(alloc_node);
          state          <= S_DONE;
        end
        S_RM_LIVE: begin
          if (lv_rdata) begin
            bucket <= scht_pkg::hash_key(ps_rdata);
            state  <= S_RM_HEAD;
          end else begin
            state <= S_DONE;
          end
        end
        S_RM_HEAD: begin
          cur   <= bh_rdata;
          prev  <= '0;
          steps <= '0;
          state <= S_RM_WALK;
        end
        S_RM_WALK: begin
          if (walk_end) begin
            state <= S_RM_FIN;
          end else if (cur == target) begin
            state <= S_RM_UNLINK;
          end else begin
            state <= S_RM_STEP;
          end
        end
        S_RM_STEP: begin
          prev  <= cur;
          cur   <= nx_rdata;
          steps <= steps + LW'(1);
          state <= S_RM_WALK;
        end
        S_RM_UNLINK: begin
          state <= S_RM_FIN;
        end
        S_RM_FIN: begin
          free_head <= target;
          if (count != '0) begin
            count <= count - LW'(1);
          end
          res.hit        <= 1'b1;
          res.handle_out <= handle;
          state          <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_data <= {res.hit, res.created, res.handle_out, res.pool_full,
                         scht_pkg::COUNT_W'(count)};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign empty  = !out_valid;
  assign result = out_data;

endmodule

// ----- rtl/core/spatial_cell_hash_table_top.sv -----
// Top level of the spatial cell hash table: front queue plus chain engine.
// After reset the block clears its bucket heads and live flags in one pass
// over the larger of the bucket count and the pool size; requests are
// queued but not served during that pass. A find or give walks its bucket
// chain until the key matches or the chain ends; a give that misses then
// takes a node from the free list or, when that is empty, a never-used node.
// A remove checks that the handle is live, walks the chain up to and
// including the removed node, unlinks it and returns it to the free list;
// a remove of a node that is not live and the unused opcode go straight to
// the result. Each visited node passes through a walk state and a compare
// or step state, as the node memories have registered read ports.
// A two-entry queue accepts requests while the engine works, and a result
// register holds a finished result while the engine starts on the next
// request; the engine waits when that register is still occupied.
module spatial_cell_hash_table_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  scht_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output scht_pkg::result_t result
);

  logic                 q_valid;
  logic                 q_pop;
  scht_pkg::front_req_t q_req;

  scht_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  scht_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .empty(empty), .pop(pop), .result(result)
  );

endmodule

// ----- rtl/core/scht_checker.sv -----
// Port-level checks of the spatial cell hash table, bound to the top level.
`include "spatial_cell_hash_table_top_macros.svh"

module scht_checker (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input scht_pkg::item_t   item,
  input logic              empty,
  input logic              pop,
  input scht_pkg::result_t result
);

  // A waiting result stays in place until it is taken.
  `SCHT_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(result))
  // A created node is never also a hit or a full pool.
  `SCHT_ASSERT_NOW(a_created, clk, rst, !empty && result.created, !result.hit && !result.pool_full)
  // A full pool reports no handle.
  `SCHT_ASSERT_NOW(a_full, clk, rst, !empty && result.pool_full, result.handle_out == '0 && !result.hit)
  // The live count never exceeds the pool.
  `SCHT_ASSERT_NOW(a_count, clk, rst, !empty, result.live_count <= scht_pkg::COUNT_W'(scht_pkg::POOL_NODES))

endmodule

bind spatial_cell_hash_table_top scht_checker u_scht_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench of the spatial cell hash table top level.
module tb;
  import scht_pkg::*;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;

  spatial_cell_hash_table_top DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  localparam int  TIMEOUT_CYCLES = 4000000;
  localparam int  HOLD_LEN = 300;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Shadow copy of the table state.
  logic [LINK_W-1:0]  head_mirror [BUCKETS];
  logic [LINK_W-1:0]  next_mirror [POOL_NODES];
  logic [KEY_W-1:0]   key_mirror  [POOL_NODES];
  logic               live_mirror [POOL_NODES];
  logic [LINK_W-1:0]  free_mirror;
  int                 fresh_mirror;
  int                 count_mirror;

  result_t pending_results [$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      sent_count;
  int      checked_count = 0;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_seq = 0;
  int      hold_seen;
  int      hold_cycles;
  int      live_handles [$];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Apply one request to the shadow table and return the expected result.
  function automatic result_t table_apply(item_t req);
    result_t             r;
    logic [KEY_W-1:0]    key;
    logic [31:0]         sum;
    logic [BUCKET_W-1:0] b;
    logic [LINK_W-1:0]   link;
    logic [LINK_W-1:0]   prev;
    logic [NODE_W-1:0]   node;
    logic                got;
    int                  steps;
    r = '0;
    key = {req.pos_z, req.pos_y, req.pos_x};
    sum = 32'(req.pos_x) + (32'(req.pos_y) << 3) + (32'(req.pos_z) << 6);
    b = sum[BUCKET_W-1:0];
    if (req.op == OP_FIND || req.op == OP_GIVE) begin
      link = head_mirror[b];
      steps = 0;
      while (link != '0 && steps < POOL_NODES) begin
        node = NODE_W'(link - LINK_W'(1));
        if (key_mirror[node] == key) break;
        link = next_mirror[node];
        steps++;
      end
      if (link != '0 && steps < POOL_NODES) begin
        r.hit = 1'b1;
        r.handle_out = HANDLE_W'(link - LINK_W'(1));
      end else if (req.op == OP_GIVE) begin
        got = 1'b1;
        node = '0;
        if (free_mirror != '0) begin
          node = NODE_W'(free_mirror - LINK_W'(1));
          free_mirror = next_mirror[node];
        end else if (fresh_mirror < POOL_NODES) begin
          node = NODE_W'(fresh_mirror);
          fresh_mirror++;
        end else begin
          got = 1'b0;
        end
        if (got) begin
          key_mirror[node] = key;
          next_mirror[node] = head_mirror[b];
          head_mirror[b] = LINK_W'(node) + LINK_W'(1);
          live_mirror[node] = 1'b1;
          count_mirror++;
          r.created = 1'b1;
          r.handle_out = HANDLE_W'(node);
        end else begin
          r.pool_full = 1'b1;
        end
      end
    end else if (req.op == OP_REMOVE) begin
      node = NODE_W'(req.handle_in);
      if (int'(req.handle_in) < POOL_NODES && live_mirror[node]) begin
        sum = 32'(key_mirror[node][COORD_BITS-1:0])
            + (32'(key_mirror[node][2*COORD_BITS-1:COORD_BITS]) << 3)
            + (32'(key_mirror[node][KEY_W-1:2*COORD_BITS]) << 6);
        b = sum[BUCKET_W-1:0];
        prev = '0;
        link = head_mirror[b];
        steps = 0;
        while (link != '0 && steps < POOL_NODES) begin
          if (link == LINK_W'(node) + LINK_W'(1)) begin
            if (prev == '0) head_mirror[b] = next_mirror[node];
            else next_mirror[NODE_W'(prev - LINK_W'(1))] = next_mirror[node];
            break;
          end
          prev = link;
          link = next_mirror[NODE_W'(link - LINK_W'(1))];
          steps++;
        end
        live_mirror[node] = 1'b0;
        next_mirror[node] = free_mirror;
        free_mirror = LINK_W'(node) + LINK_W'(1);
        if (count_mirror > 0) count_mirror--;
        r.hit = 1'b1;
        r.handle_out = req.handle_in;
      end
    end
    r.live_count = COUNT_W'(count_mirror);
    return r;
  endfunction

  // Send one request, idling at random beforehand.
  task automatic send_request(item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results.push_back(table_apply(req));
    sent_count++;
  endtask

  function automatic item_t make_item(logic [1:0] op, int x, int y, int z, int h);
    item_t t;
    t.op = op;
    t.pos_x = 16'(x);
    t.pos_y = 16'(y);
    t.pos_z = 16'(z);
    t.handle_in = HANDLE_W'(h);
    return t;
  endfunction

  // Small coordinates collide often and build chains.
  function automatic int near_coord();
    return $urandom_range(7) - 4;
  endfunction

  // Stop offering requests and wait until every result has come back.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Directed: extremes of coordinates, every operation, bad handles.
  task automatic test_directed();
    send_request(make_item(OP_FIND, 0, 0, 0, 0));
    send_request(make_item(OP_REMOVE, 0, 0, 0, 0));
    send_request(make_item(OP_GIVE, 0, 0, 0, 0));
    send_request(make_item(OP_GIVE, 0, 0, 0, 0));
    send_request(make_item(OP_FIND, 0, 0, 0, 1023));
    send_request(make_item(OP_GIVE, -32768, -32768, -32768, 0));
    send_request(make_item(OP_GIVE, 32767, 32767, 32767, 1023));
    send_request(make_item(OP_GIVE, 8, -1, 0, 0));
    send_request(make_item(OP_GIVE, 0, 0, 1, 0));
    send_request(make_item(OP_GIVE, 64, 0, 0, 0));
    send_request(make_item(OP_FIND, 32767, 32767, 32767, 0));
    send_request(make_item(OP_FIND, 8, -1, 0, 0));
    send_request(make_item(OP_UNUSED, -1, -1, -1, 1023));
    send_request(make_item(OP_REMOVE, 0, 0, 0, 1023));
    send_request(make_item(OP_REMOVE, 0, 0, 0, 4));
    send_request(make_item(OP_FIND, 0, 0, 1, 0));
    send_request(make_item(OP_FIND, 64, 0, 0, 0));
    send_request(make_item(OP_REMOVE, 0, 0, 0, 4));
    send_request(make_item(OP_GIVE, 1, 2, 3, 0));
    send_request(make_item(OP_REMOVE, 0, 0, 0, 0));
    send_request(make_item(OP_FIND, 0, 0, 0, 0));
    send_request(make_item(OP_GIVE, 5, 5, 5, 0));
    drain_results();
  endtask

  // Random mix; mostly well-formed operations on clustered positions.
  task automatic test_random(int count);
    int    sel;
    item_t t;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      t = make_item(OP_GIVE, near_coord(), near_coord(), near_coord(), $urandom_range(1023));
      if (sel < 10) begin
        t.pos_x = 16'($urandom); t.pos_y = 16'($urandom); t.pos_z = 16'($urandom);
        t.op = 2'($urandom_range(3));
      end else if (sel < 40) t.op = OP_FIND;
      else if (sel < 70) t.op = OP_GIVE;
      else begin
        t.op = OP_REMOVE;
        if (sel < 95) begin
          t.handle_in = HANDLE_W'($urandom_range(fresh_mirror > 0 ? fresh_mirror : 1));
        end
      end
      send_request(t);
    end
  endtask

  // Fill the pool to exhaustion, check pool full, then reuse freed nodes.
  task automatic test_pool_full();
    int fill;
    fill = POOL_NODES - count_mirror + 4;
    for (int i = 0; i < fill; i++)
      send_request(make_item(OP_GIVE, 1000 + i, i >> 5, -1000 - i, 0));
    drain_results();
    for (int i = 0; i < POOL_NODES; i++)
      if (live_mirror[i]) live_handles.push_back(i);
    live_handles.shuffle();
    for (int i = 0; i < 8 && i < live_handles.size(); i++)
      send_request(make_item(OP_REMOVE, 0, 0, 0, live_handles[i]));
    send_request(make_item(OP_GIVE, 9, 9, 9, 0));
    send_request(make_item(OP_GIVE, 9, 9, 9, 0));
    send_request(make_item(OP_FIND, 9, 9, 9, 0));
    drain_results();
  endtask

  // Receiver holds off long enough for the input side to stall.
  task automatic test_backpressure();
    hold_seq++;
    for (int i = 0; i < 20; i++)
      send_request(make_item(OP_GIVE, near_coord(), near_coord(), near_coord(), 0));
    drain_results();
  endtask

  // Result checker with random idling and a hold-off counter.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_cycles <= 0;
      hold_seen <= hold_seq;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          if (result.hit !== pending_results[0].hit) begin
            $error("hit: expected %0d actual %0d", pending_results[0].hit, result.hit);
            error_count++;
          end
          if (result.created !== pending_results[0].created) begin
            $error("created: expected %0d actual %0d",
                   pending_results[0].created, result.created);
            error_count++;
          end
          if (result.handle_out !== pending_results[0].handle_out) begin
            $error("handle_out: expected %0d actual %0d",
                   pending_results[0].handle_out, result.handle_out);
            error_count++;
          end
          if (result.pool_full !== pending_results[0].pool_full) begin
            $error("pool_full: expected %0d actual %0d",
                   pending_results[0].pool_full, result.pool_full);
            error_count++;
          end
          if (result.live_count !== pending_results[0].live_count) begin
            $error("live_count: expected %0d actual %0d",
                   pending_results[0].live_count, result.live_count);
            error_count++;
          end
          void'(pending_results.pop_front());
          checked_count++;
        end
      end
      if (hold_seen != hold_seq) begin
        hold_seen <= hold_seq;
        hold_cycles <= HOLD_LEN;
        pop <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    sent_count = 0;
    send_idle_pct = 37;
    recv_idle_pct = 58;
    foreach (head_mirror[i]) head_mirror[i] = '0;
    foreach (live_mirror[i]) live_mirror[i] = 1'b0;
    free_mirror = '0;
    fresh_mirror = 0;
    count_mirror = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(50);
    test_backpressure();
    send_idle_pct = 58;
    recv_idle_pct = 37;
    test_random(50);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(50);
    test_pool_full();
    drain_results();
    repeat (200) @(posedge clk);
    $display("Sent %0d requests, checked %0d results: find, give, remove,",
             sent_count, checked_count);
    $display("unused opcode, coordinate extremes, pool exhaustion and back-pressure.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
